// ----- design/loht_pkg.sv -----
// Shared types and constants for the LRU open handle tracker.
package loht_pkg;

   // Default number of tracked entries.
   localparam int NUM_ENTRIES_DEF = 512;

   // Fixed field widths.
   localparam int ENTRY_W = 9;
   localparam int CFG_W   = 10;
   localparam int COUNT_W = 10;

   // Common width for mixed-width compares (covers up to 65535 entries).
   localparam int WIDE_W = 16;

   // Reset value of the open limit register.
   localparam logic [CFG_W-1:0] MAX_OPEN_RST = CFG_W'(40);

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_W0,
      ST_W1
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic clear;
      logic accept;
      logic look;
      logic w0;
      logic w1;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

// ----- design/loht_ctrl.sv -----
// Controller state machine: clearing pass, accept, lookup and two write steps.
module loht_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  loht_pkg::status_type  status,
   output loht_pkg::cmd_type     cmd,
   output logic                  busy
);

   loht_pkg::state_type state_ff;
   loht_pkg::state_type state_in;

   // Hold state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= loht_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance through clear, then the access sequence of idle, lookup and two write steps.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         loht_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = loht_pkg::ST_IDLE;
            end
         end
         loht_pkg::ST_IDLE: begin
            if (start) begin
               state_in = loht_pkg::ST_LOOK;
            end
         end
         loht_pkg::ST_LOOK: state_in = loht_pkg::ST_W0;
         loht_pkg::ST_W0:   state_in = loht_pkg::ST_W1;
         loht_pkg::ST_W1:   state_in = loht_pkg::ST_IDLE;
         default:           state_in = loht_pkg::ST_CLEAR;
      endcase
   end

   // Decode commands.
   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      unique case (state_ff)
         loht_pkg::ST_CLEAR: cmd.clear = 1'b1;
         loht_pkg::ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         loht_pkg::ST_LOOK: cmd.look = 1'b1;
         loht_pkg::ST_W0:   cmd.w0 = 1'b1;
         loht_pkg::ST_W1:   cmd.w1 = 1'b1;
         default:           cmd = '0;
      endcase
   end

endmodule

// ----- design/loht_dp.sv -----
// Datapath: open flags, recency link memories, list head/tail, count and result.
module loht_dp #(
   parameter int NUM_ENTRIES = loht_pkg::NUM_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  loht_pkg::cmd_type             cmd,
   output loht_pkg::status_type          status,
   input  logic [loht_pkg::ENTRY_W-1:0]  req_entry_id,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [loht_pkg::CFG_W-1:0]    csr_max_open,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic                          rsp_evicted,
   output logic [loht_pkg::ENTRY_W-1:0]  rsp_evicted_id,
   output logic [loht_pkg::COUNT_W-1:0]  rsp_open_count
);

   localparam int IDX_W  = $clog2(NUM_ENTRIES);
   localparam int LINK_W = IDX_W + 1;
   localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);
   localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(NUM_ENTRIES);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_ENTRIES - 1);

   // Memories
   logic              open_mem [NUM_ENTRIES];
   logic [LINK_W-1:0] prev_mem [NUM_ENTRIES];
   logic [LINK_W-1:0] next_mem [NUM_ENTRIES];

   // Control and list state
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [LINK_W-1:0] mru_ff;
   logic [LINK_W-1:0] mru_in;
   logic [LINK_W-1:0] lru_ff;
   logic [LINK_W-1:0] lru_in;
   logic [IDX_W-1:0]  clr_idx_ff;
   logic [loht_pkg::CFG_W-1:0] max_open_ff;
   logic              rsp_valid_ff;

   // Per-transaction registers
   logic [IDX_W-1:0]  id_ff;
   logic              id_ok_ff;
   logic              open_rd_ff;
   logic [LINK_W-1:0] prev_rd_ff;
   logic [LINK_W-1:0] next_rd_ff;
   logic [LINK_W-1:0] lru_prev_rd_ff;
   logic              move_ff;
   logic              miss_ff;
   logic              evict_ff;
   logic [LINK_W-1:0] p_ff;
   logic [LINK_W-1:0] n_ff;
   logic [LINK_W-1:0] front_ff;
   logic [LINK_W-1:0] victim_ff;

   // Result registers
   logic                         hit_ff;
   logic                         evicted_ff;
   logic [loht_pkg::ENTRY_W-1:0] evicted_id_ff;
   logic [loht_pkg::COUNT_W-1:0] open_count_ff;

   // Lookup decisions
   logic [loht_pkg::WIDE_W-1:0] id_wide;
   logic                        req_ok;
   logic [IDX_W-1:0]            req_idx;
   logic [LINK_W-1:0]           id_link;
   logic                        is_mru;
   logic                        is_lru;
   logic [LINK_W-1:0]           p_look;
   logic [LINK_W-1:0]           n_look;
   logic [LINK_W-1:0]           vp_look;
   logic                        hit_look;
   logic                        move_look;
   logic                        miss_look;
   logic                        evict_look;
   logic [loht_pkg::CFG_W-1:0]  limit;
   logic [LINK_W-1:0]           front_look;

   // Write ports
   logic              open_we;
   logic [IDX_W-1:0]  open_wa;
   logic              open_wd;
   logic              prev_we;
   logic [IDX_W-1:0]  prev_wa;
   logic [LINK_W-1:0] prev_wd;
   logic              next_we;
   logic [IDX_W-1:0]  next_wa;
   logic [LINK_W-1:0] next_wd;

   assign csr_ready = 1'b1;

   // Qualify the requested id.
   assign id_wide = loht_pkg::WIDE_W'(req_entry_id);
   assign req_ok  = id_wide < loht_pkg::WIDE_W'(NUM_ENTRIES);
   assign req_idx = IDX_W'(req_entry_id);

   assign status.clear_last = (clr_idx_ff == LAST_IDX);

   // Hold the open limit.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_open_ff <= loht_pkg::MAX_OPEN_RST;
      end else if (csr_valid && csr_ready) begin
         max_open_ff <= csr_max_open;
      end
   end

   // Advance the clearing pass over the open flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clear) begin
         clr_idx_ff <= clr_idx_ff + IDX_W'(1);
      end
   end

   // Latch the id and read all memories at accept.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         id_ff          <= req_idx;
         id_ok_ff       <= req_ok;
         open_rd_ff     <= open_mem[req_idx];
         prev_rd_ff     <= prev_mem[req_idx];
         next_rd_ff     <= next_mem[req_idx];
         lru_prev_rd_ff <= prev_mem[lru_ff[IDX_W-1:0]];
      end
   end

   // Decide hit, move and eviction. The prev link of the most recent entry
   // and the next link of the least recent entry are treated as none.
   always_comb begin
      id_link    = LINK_W'(id_ff);
      is_mru     = (id_link == mru_ff);
      is_lru     = (id_link == lru_ff);
      p_look     = is_mru ? NONE_LINK : prev_rd_ff;
      n_look     = is_lru ? NONE_LINK : next_rd_ff;
      vp_look    = (lru_ff == mru_ff) ? NONE_LINK : lru_prev_rd_ff;
      hit_look   = id_ok_ff && open_rd_ff;
      move_look  = hit_look && !is_mru;
      miss_look  = id_ok_ff && !open_rd_ff;
      limit      = (max_open_ff == '0) ? loht_pkg::CFG_W'(1) : max_open_ff;
      evict_look = miss_look
                   && (loht_pkg::WIDE_W'(count_ff) >= loht_pkg::WIDE_W'(limit))
                   && (count_ff != '0)
                   && (lru_ff != NONE_LINK);
      front_look = (evict_look && (lru_ff == mru_ff)) ? NONE_LINK : mru_ff;

      mru_in   = mru_ff;
      lru_in   = lru_ff;
      count_in = count_ff;
      if (move_look) begin
         mru_in = id_link;
         if (n_look == NONE_LINK) begin
            lru_in = p_look;
         end
      end else if (miss_look) begin
         mru_in   = id_link;
         count_in = count_ff + CNT_W'(1) - CNT_W'(evict_look);
         if (front_look == NONE_LINK) begin
            lru_in = id_link;
         end else if (evict_look) begin
            lru_in = vp_look;
         end
      end
   end

   // Hold list head, tail and count.
   always_ff @(posedge clock) begin
      if (reset) begin
         mru_ff   <= NONE_LINK;
         lru_ff   <= NONE_LINK;
         count_ff <= '0;
      end else if (cmd.look) begin
         mru_ff   <= mru_in;
         lru_ff   <= lru_in;
         count_ff <= count_in;
      end
   end

   // Latch the write plan and the result.
   always_ff @(posedge clock) begin
      if (cmd.look) begin
         move_ff       <= move_look;
         miss_ff       <= miss_look;
         evict_ff      <= evict_look;
         p_ff          <= p_look;
         n_ff          <= n_look;
         front_ff      <= front_look;
         victim_ff     <= lru_ff;
         hit_ff        <= hit_look;
         evicted_ff    <= evict_look;
         evicted_id_ff <= evict_look ? loht_pkg::ENTRY_W'(lru_ff) : '0;
         open_count_ff <= loht_pkg::COUNT_W'(count_in);
      end
   end

   // Strobe the result for one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.look;
      end
   end

   // Sequence the link and flag writes over the two write steps.
   always_comb begin
      open_we = 1'b0;
      open_wa = id_ff;
      open_wd = 1'b0;
      prev_we = 1'b0;
      prev_wa = front_ff[IDX_W-1:0];
      prev_wd = LINK_W'(id_ff);
      next_we = 1'b0;
      next_wa = id_ff;
      next_wd = front_ff;
      if (cmd.w0) begin
         prev_we = move_ff || (miss_ff && (front_ff != NONE_LINK));
         if (move_ff) begin
            next_we = 1'b1;
            next_wa = p_ff[IDX_W-1:0];
            next_wd = n_ff;
         end else if (miss_ff) begin
            next_we = 1'b1;
            open_we = evict_ff;
            open_wa = victim_ff[IDX_W-1:0];
         end
      end else if (cmd.w1) begin
         if (move_ff) begin
            next_we = 1'b1;
            prev_we = (n_ff != NONE_LINK);
            prev_wa = n_ff[IDX_W-1:0];
            prev_wd = p_ff;
         end else if (miss_ff) begin
            open_we = 1'b1;
            open_wd = 1'b1;
         end
      end
   end

   // Write open flags; the clearing pass owns the port after reset.
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         open_mem[clr_idx_ff] <= 1'b0;
      end else if (open_we) begin
         open_mem[open_wa] <= open_wd;
      end
   end

   // Write prev links.
   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
   end

   // Write next links.
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = hit_ff;
   assign rsp_evicted    = evicted_ff;
   assign rsp_evicted_id = evicted_id_ff;
   assign rsp_open_count = open_count_ff;

endmodule

// ----- design/lru_open_handle_tracker.sv -----
// Result: rsp_valid and the result fields are registered in the lookup step that follows each accept.
// A new access is taken only after the lookup read and two write steps on the shared link
// memories are done; busy stays high through those steps after each accept.
// Reset: synchronous; a clearing pass over all NUM_ENTRIES entries zeroes the open flags
// while busy is high. The limit register is writable at any time.
// The receiver cannot stall: each result is present for exactly one cycle.
module lru_open_handle_tracker #(
   parameter int NUM_ENTRIES = loht_pkg::NUM_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [loht_pkg::ENTRY_W-1:0]  req_entry_id,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic                          rsp_evicted,
   output logic [loht_pkg::ENTRY_W-1:0]  rsp_evicted_id,
   output logic [loht_pkg::COUNT_W-1:0]  rsp_open_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [loht_pkg::CFG_W-1:0]    csr_max_open
);

   loht_pkg::cmd_type    cmd;
   loht_pkg::status_type status;

   // Sequence each transaction.
   loht_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Hold list state and produce results.
   loht_dp #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_entry_id   (req_entry_id),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_max_open   (csr_max_open),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_evicted    (rsp_evicted),
      .rsp_evicted_id (rsp_evicted_id),
      .rsp_open_count (rsp_open_count)
   );

endmodule

// ----- test/tb_lru_open_handle_tracker.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the LRU open handle tracker, with its own recency-list model.
module tb_lru_open_handle_tracker;
   import loht_pkg::*;

   localparam int                 TRACKED        = NUM_ENTRIES_DEF;
   localparam logic [COUNT_W-1:0] NO_LINK        = COUNT_W'(TRACKED);
   localparam int                 WATCHDOG_LIMIT = 3000;
   localparam int                 SETTLE_CYCLES  = 8;

   // Expected outcome of one access, tagged with the accessed id for messages.
   typedef struct packed {
      logic [ENTRY_W-1:0] entry_id;
      logic               hit;
      logic               evicted;
      logic [ENTRY_W-1:0] evicted_id;
      logic [COUNT_W-1:0] open_count;
   } access_outcome_t;

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                start        = 1'b0;
   logic [ENTRY_W-1:0]  req_entry_id = '0;
   logic                csr_valid    = 1'b0;
   logic [CFG_W-1:0]    csr_max_open = '0;
   logic                busy;
   logic                rsp_valid;
   logic                rsp_hit;
   logic                rsp_evicted;
   logic [ENTRY_W-1:0]  rsp_evicted_id;
   logic [COUNT_W-1:0]  rsp_open_count;
   logic                csr_ready;

   lru_open_handle_tracker uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_entry_id   (req_entry_id),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_evicted    (rsp_evicted),
      .rsp_evicted_id (rsp_evicted_id),
      .rsp_open_count (rsp_open_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_max_open   (csr_max_open)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mirror of the tracker: open flags, recency links and counters.
   logic               entry_open [TRACKED];
   logic [COUNT_W-1:0] newer_link [TRACKED];
   logic [COUNT_W-1:0] older_link [TRACKED];
   logic [COUNT_W-1:0] mru_head;
   logic [COUNT_W-1:0] lru_tail;
   logic [COUNT_W-1:0] open_total;
   logic [CFG_W-1:0]   open_limit;

   logic [ENTRY_W-1:0]   access_q [$];
   access_outcome_t      outcome_q [$];
   int                   burst_left   = 1;
   int                   gap_left     = 0;
   int                   stall_cycles = 0;
   int                   fail_count   = 0;

   function automatic void clear_tracker();
      for (int i = 0; i < TRACKED; i++) begin
         entry_open[i] = 1'b0;
         newer_link[i] = NO_LINK;
         older_link[i] = NO_LINK;
      end
      mru_head   = NO_LINK;
      lru_tail   = NO_LINK;
      open_total = '0;
      open_limit = MAX_OPEN_RST;
   endfunction

   // Detach an open entry from the recency list.
   function automatic void unlink_entry(input logic [ENTRY_W-1:0] id);
      logic [COUNT_W-1:0] newer;
      logic [COUNT_W-1:0] older;
      newer = newer_link[id];
      older = older_link[id];
      if (older != NO_LINK) begin
         newer_link[older[ENTRY_W-1:0]] = newer;
      end else begin
         lru_tail = newer;
      end
      if (newer != NO_LINK) begin
         older_link[newer[ENTRY_W-1:0]] = older;
      end else begin
         mru_head = older;
      end
      newer_link[id] = NO_LINK;
      older_link[id] = NO_LINK;
   endfunction

   // Place an entry at the most recent end.
   function automatic void push_newest(input logic [ENTRY_W-1:0] id);
      newer_link[id] = NO_LINK;
      older_link[id] = mru_head;
      if (mru_head != NO_LINK) begin
         newer_link[mru_head[ENTRY_W-1:0]] = {1'b0, id};
      end else begin
         lru_tail = {1'b0, id};
      end
      mru_head = {1'b0, id};
   endfunction

   // Apply one access to the mirror and return what the block should report.
   function automatic access_outcome_t track_access(input logic [ENTRY_W-1:0] id);
      access_outcome_t    outcome;
      logic [COUNT_W-1:0] limit;
      logic [ENTRY_W-1:0] victim;
      outcome          = '0;
      outcome.entry_id = id;
      limit = (open_limit == '0) ? COUNT_W'(1) : open_limit;
      if (entry_open[id]) begin
         outcome.hit = 1'b1;
         unlink_entry(id);
         push_newest(id);
      end else begin
         // Close the least recent entry when the limit is reached.
         if (open_total >= limit && open_total != '0 && lru_tail != NO_LINK) begin
            victim = lru_tail[ENTRY_W-1:0];
            unlink_entry(victim);
            entry_open[victim] = 1'b0;
            open_total         = open_total - COUNT_W'(1);
            outcome.evicted    = 1'b1;
            outcome.evicted_id = victim;
         end
         entry_open[id] = 1'b1;
         push_newest(id);
         open_total = open_total + COUNT_W'(1);
      end
      outcome.open_count = open_total;
      return outcome;
   endfunction

   function automatic void check_field(input string what, input logic [ENTRY_W-1:0] id,
                                       input logic [COUNT_W-1:0] want,
                                       input logic [COUNT_W-1:0] got);
      if (want !== got) begin
         $display("%0t: entry %0d %s expected %0d actual %0d", $time, id, what, want, got);
         fail_count++;
      end
   endfunction

   // Drive queued accesses in bursts separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            void'(access_q.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
            end
         end else if (gap_left > 0) begin
            gap_left--;
         end
         if (access_q.size() != 0 && gap_left == 0) begin
            start        <= 1'b1;
            req_entry_id <= access_q[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Check each result strobe, then predict the transaction accepted at this edge.
   always @(posedge clock) begin
      access_outcome_t want;
      if (!reset) begin
         if (rsp_valid) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: unexpected result hit %0b evicted %0b id %0d count %0d",
                        $time, rsp_hit, rsp_evicted, rsp_evicted_id, rsp_open_count);
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               check_field("hit", want.entry_id, COUNT_W'(want.hit), COUNT_W'(rsp_hit));
               check_field("evicted", want.entry_id, COUNT_W'(want.evicted),
                           COUNT_W'(rsp_evicted));
               check_field("evicted_id", want.entry_id, COUNT_W'(want.evicted_id),
                           COUNT_W'(rsp_evicted_id));
               check_field("open_count", want.entry_id, want.open_count, rsp_open_count);
            end
         end
         if (start && !busy) begin
            outcome_q.push_back(track_access(req_entry_id));
         end
      end
   end

   // End the run if no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("lru_open_handle_tracker regression: fail");
            $finish;
         end
      end
   end

   // Hold until every queued access is accepted and every result has come back.
   task automatic wait_idle();
      do @(posedge clock);
      while (access_q.size() != 0 || outcome_q.size() != 0 || start);
   endtask

   task automatic write_limit(input logic [CFG_W-1:0] value);
      csr_valid    <= 1'b1;
      csr_max_open <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      open_limit = value;
      csr_valid <= 1'b0;
   endtask

   task automatic add_access(input logic [ENTRY_W-1:0] id);
      access_q.push_back(id);
   endtask

   // Random accesses mostly from a window of ids so hits and evictions both occur.
   task automatic pool_phase(input int count, input int pool_size);
      int base;
      base = $urandom_range(0, TRACKED - 1);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            add_access(ENTRY_W'($urandom_range(0, TRACKED - 1)));
         end else begin
            add_access(ENTRY_W'(base + $urandom_range(0, pool_size - 1)));
         end
      end
   endtask

   initial begin
      int sweep [TRACKED];
      int pick;
      int swap;
      clear_tracker();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset limit: extremes of the id and alternating bit patterns, with repeats.
      add_access(9'd0);
      add_access(9'd511);
      add_access(9'd0);
      add_access(9'd511);
      add_access(9'd170);
      add_access(9'd341);
      wait_idle();

      // Limit of one: every miss evicts the least recent open entry.
      write_limit(CFG_W'(1));
      add_access(9'd3);
      add_access(9'd3);
      add_access(9'd9);
      add_access(9'd3);
      add_access(9'd0);
      add_access(9'd511);
      wait_idle();

      // Limit of zero behaves as a limit of one.
      write_limit(CFG_W'(0));
      add_access(9'd1);
      add_access(9'd2);
      add_access(9'd2);
      add_access(9'd1);
      wait_idle();

      write_limit(CFG_W'(8));
      pool_phase(80, 14);
      wait_idle();

      pick = $urandom_range(2, 60);
      write_limit(CFG_W'(pick));
      pool_phase(60, 2 * pick);
      wait_idle();

      write_limit(CFG_W'(200));
      pool_phase(80, 400);
      wait_idle();

      // Lower the limit below the open count: misses must keep the count steady.
      write_limit(CFG_W'(6));
      pool_phase(80, 12);
      wait_idle();

      // Limit beyond the entry count never evicts.
      write_limit(CFG_W'(1023));
      pool_phase(60, TRACKED);
      wait_idle();

      // Open every entry in shuffled order to reach the full count.
      write_limit(CFG_W'(512));
      for (int i = 0; i < TRACKED; i++) sweep[i] = i;
      for (int i = TRACKED - 1; i > 0; i--) begin
         pick        = $urandom_range(0, i);
         swap        = sweep[i];
         sweep[i]    = sweep[pick];
         sweep[pick] = swap;
      end
      for (int i = 0; i < TRACKED; i++) add_access(ENTRY_W'(sweep[i]));
      pool_phase(30, TRACKED);
      wait_idle();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("lru_open_handle_tracker regression: pass");
      end else begin
         $display("lru_open_handle_tracker regression: fail");
      end
      $finish;
   end

endmodule
